### design/skt_pkg.sv
package skt_pkg;

    localparam int KEY_W             = 32;
    localparam int PAY_IN_W          = 32;
    localparam int STATUS_W          = 2;
    localparam int POS_W             = 8;
    localparam int HELD_W            = 8;
    localparam int S_TDATA_W         = 64;
    localparam int M_TDATA_W         = 56;
    localparam int DEPTH_DEF         = 128;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } skt_ctrl_t;

endpackage

### design/skt_cell.sv
module skt_cell
    import skt_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                     aclk,
    input  skt_ctrl_t                ctrl,
    input  logic                     occupied,
    input  logic [KEY_W-1:0]         cmp_key,
    input  logic [KEY_W-1:0]         ins_key,
    input  logic [PAYLOAD_WIDTH-1:0] ins_payload,
    input  logic                     prev_lt,
    input  logic [KEY_W-1:0]         prev_key,
    input  logic [PAYLOAD_WIDTH-1:0] prev_payload,
    output logic                     lt,
    output logic                     eq,
    output logic                     bnd,
    output logic [KEY_W-1:0]         key,
    output logic [PAYLOAD_WIDTH-1:0] payload
);

    logic                     lt_reg;
    logic                     eq_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            lt_reg <= occupied && ($signed(key_reg) < $signed(cmp_key));
            eq_reg <= occupied && (key_reg == cmp_key);
        end
        if (ctrl.shift_en && !lt_reg) begin
            if (bnd) begin
                key_reg     <= ins_key;
                payload_reg <= ins_payload;
            end else begin
                key_reg     <= prev_key;
                payload_reg <= prev_payload;
            end
        end
    end

    assign bnd     = !lt_reg && prev_lt;
    assign lt      = lt_reg;
    assign eq      = eq_reg;
    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

### design/skt_encode.sv
module skt_encode
    import skt_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
    localparam int IDX_W        = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0]         sel,
    input  logic [PAYLOAD_WIDTH-1:0] pay_arr [DEPTH],
    output logic [IDX_W-1:0]         idx,
    output logic [PAYLOAD_WIDTH-1:0] pay
);

    always_comb begin
        idx = '0;
        pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel[i]) begin
                idx = idx | IDX_W'(i);
                pay = pay | pay_arr[i];
            end
        end
    end

endmodule

### design/sorted_key_table.sv
// Channel  Dir  tdata (low bit up)                              tuser
// s_       in   key[31:0], payload[63:32]                       kind[0]
// m_       out  status[1:0], position[9:2], payload_out[41:10], -
//               entries_held[49:42], zero fill[55:50]
//
// Every cell compares its key on acceptance, and the shift and result are
// committed in the update state from the registered comparison flags.
// Reset clears the entry count, the control state and the result valid flag.
// A result waiting on m_tready holds the next request in its commit cycle.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key, payload
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, position, payload_out, entries_held
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     kind_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]     m_data_reg, m_data_next;

    skt_ctrl_t                ctrl;
    logic                     commit;
    logic                     full;
    logic [DEPTH-1:0]         lt_vec, eq_vec, bnd_vec, sel_vec;
    logic [KEY_W-1:0]         key_arr [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_arr [DEPTH];
    logic [IDX_W-1:0]         enc_idx;
    logic [PAYLOAD_WIDTH-1:0] enc_pay;
    logic [PAYLOAD_WIDTH+PAY_IN_W-1:0] pay_in_ext;
    logic [PAYLOAD_WIDTH+PAY_IN_W-1:0] pay_out_ext;
    logic [IDX_W+POS_W-1:0]   pos_ext;
    logic [CNT_W+HELD_W-1:0]  held_ext;
    logic [STATUS_W-1:0]      res_status;
    logic [POS_W-1:0]         res_pos;
    logic [PAY_IN_W-1:0]      res_pay;

    assign s_tready    = (state_reg == ST_IDLE);
    assign commit      = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign ctrl.cmp_en   = s_tvalid && s_tready;
    assign ctrl.shift_en = commit && (kind_reg == KIND_INSERT) && !full;

    assign pay_in_ext  = {{PAYLOAD_WIDTH{1'b0}}, s_tdata[2*PAY_IN_W-1:PAY_IN_W]};

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic                     prev_lt;
            logic [KEY_W-1:0]         prev_key;
            logic [PAYLOAD_WIDTH-1:0] prev_pay;
            if (i == 0) begin : g_head
                assign prev_lt  = 1'b1;
                assign prev_key = key_reg;
                assign prev_pay = pay_reg;
            end else begin : g_body
                assign prev_lt  = lt_vec[i-1];
                assign prev_key = key_arr[i-1];
                assign prev_pay = pay_arr[i-1];
            end
            skt_cell #(
                .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (CNT_W'(i) < count_reg),
                .cmp_key     (s_tdata[KEY_W-1:0]),
                .ins_key     (key_reg),
                .ins_payload (pay_reg),
                .prev_lt     (prev_lt),
                .prev_key    (prev_key),
                .prev_payload(prev_pay),
                .lt          (lt_vec[i]),
                .eq          (eq_vec[i]),
                .bnd         (bnd_vec[i]),
                .key         (key_arr[i]),
                .payload     (pay_arr[i])
            );
        end
    endgenerate

    assign sel_vec = (kind_reg == KIND_INSERT) ? bnd_vec : (bnd_vec & eq_vec);

    skt_encode #(
        .DEPTH        (DEPTH),
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_encode (
        .sel    (sel_vec),
        .pay_arr(pay_arr),
        .idx    (enc_idx),
        .pay    (enc_pay)
    );

    assign pay_out_ext = {{PAY_IN_W{1'b0}}, enc_pay};
    assign pos_ext     = {{POS_W{1'b0}}, enc_idx};

    always_comb begin
        count_next = count_reg;
        res_status = ST_MISS;
        res_pos    = '0;
        res_pay    = '0;
        if (kind_reg == KIND_INSERT) begin
            if (full) begin
                res_status = ST_FULL;
            end else begin
                res_status = ST_OK;
                res_pos    = pos_ext[POS_W-1:0];
                count_next = count_reg + 1'b1;
            end
        end else if (|sel_vec) begin
            res_status = ST_OK;
            res_pos    = pos_ext[POS_W-1:0];
            res_pay    = pay_out_ext[PAY_IN_W-1:0];
        end
        if (!commit) begin
            count_next = count_reg;
        end
        held_ext = {{HELD_W{1'b0}}, count_next};
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.cmp_en) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_TDATA_W - STATUS_W - POS_W - PAY_IN_W - HELD_W){1'b0}},
                                    held_ext[HELD_W-1:0], res_pay, res_pos, res_status};
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (ctrl.cmp_en) begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            pay_reg  <= pay_in_ext[PAYLOAD_WIDTH-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance entry count");

    a_one_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD |-> $onehot0(bnd_vec))
        else $error("more than one insertion boundary in the chain");

    a_insert_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift_en |-> $onehot(bnd_vec))
        else $error("insert without an insertion boundary");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[STATUS_W-1:0] == ST_FULL) |-> full)
        else $error("full status reported while table has room");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import skt_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [PAY_IN_W-1:0] payload_out;
        logic [HELD_W-1:0]   entries_held;
    } table_response_t;

    // Shadow of the sorted table: predicts the response to every accepted request.
    class key_table_shadow;
        logic signed [KEY_W-1:0] key_mem[DEPTH_DEF];
        logic [PAY_IN_W-1:0]     pay_mem[DEPTH_DEF];
        int                      held;
        table_response_t         expected_responses[$];
        int                      mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_responses.size();
        endfunction

        function void note_request(logic kind, logic signed [KEY_W-1:0] key,
                                   logic [PAY_IN_W-1:0] pay);
            table_response_t r;
            int              p;
            r.status      = ST_OK;
            r.position    = '0;
            r.payload_out = '0;
            p = 0;
            for (int i = 0; i < held; i++) begin
                if (key_mem[i] < key) begin
                    p++;
                end
            end
            if (kind == KIND_INSERT) begin
                if (held >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = held; i > p; i--) begin
                        key_mem[i] = key_mem[i-1];
                        pay_mem[i] = pay_mem[i-1];
                    end
                    key_mem[p] = key;
                    pay_mem[p] = pay;
                    held++;
                    r.position = p[POS_W-1:0];
                end
            end else if (p < held && key_mem[p] == key) begin
                r.position    = p[POS_W-1:0];
                r.payload_out = pay_mem[p];
            end else begin
                r.status = ST_MISS;
            end
            r.entries_held = held[HELD_W-1:0];
            expected_responses.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_response(logic [M_TDATA_W-1:0] d);
            table_response_t want;
            if (expected_responses.size() == 0) begin
                report($sformatf("response %h with no request outstanding", d));
                return;
            end
            want = expected_responses.pop_front();
            if (d[1:0] != want.status)
                report($sformatf("status %0d, expected %0d", d[1:0], want.status));
            if (d[9:2] != want.position)
                report($sformatf("position %0d, expected %0d", d[9:2], want.position));
            if (d[41:10] != want.payload_out)
                report($sformatf("payload %h, expected %h", d[41:10], want.payload_out));
            if (d[49:42] != want.entries_held)
                report($sformatf("entries held %0d, expected %0d", d[49:42],
                                 want.entries_held));
            if (d[M_TDATA_W-1:50] != '0)
                report($sformatf("fill bits %h not zero", d[M_TDATA_W-1:50]));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // key, payload
    logic                 s_tuser;    // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // status, position, payload_out, entries_held

    key_table_shadow         sb;
    logic                    quiet;
    int                      cycles;
    logic signed [KEY_W-1:0] known_keys[$];

    sorted_key_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_response(m_tdata);
        end
    end

    task automatic send_request(input logic kind, input logic signed [KEY_W-1:0] key,
                                input logic [PAY_IN_W-1:0] pay);
        while (!quiet && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pay, key};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, key, pay);
        if (kind == KIND_INSERT && known_keys.size() < DEPTH_DEF) begin
            known_keys.push_back(key);
        end
        @(negedge aclk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(logic kind);
        if (kind == KIND_LOOKUP && known_keys.size() > 0 && $urandom_range(99) < 60) begin
            return known_keys[$urandom_range(known_keys.size() - 1)];
        end
        case ($urandom_range(5))
            0, 1:    return $urandom_range(16) - 8;
            2: begin
                case ($urandom_range(3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic kind;
        int   insert_chance;
        sb       = new();
        quiet    = 1'b0;
        cycles   = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_LOOKUP;
        m_tready = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(KIND_LOOKUP, 32'sd0, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'sh8000_0000, 32'h0000_0000);
        send_request(KIND_INSERT, 32'sd0, 32'hA5A5_A5A5);
        send_request(KIND_INSERT, 32'sd0, 32'h5A5A_5A5A);
        send_request(KIND_LOOKUP, 32'sd0, 32'h0000_0000);
        send_request(KIND_LOOKUP, 32'sh7FFF_FFFF, 32'h1234_5678);
        send_request(KIND_LOOKUP, 32'sh8000_0000, 32'h0000_0000);
        send_request(KIND_LOOKUP, -32'sd1, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, -32'sd1, 32'h8000_0001);
        send_request(KIND_LOOKUP, -32'sd1, 32'h0000_0000);
        send_request(KIND_INSERT, 32'sd1, 32'h0000_0001);
        send_request(KIND_LOOKUP, 32'sd1, 32'h0000_0000);
        send_request(KIND_LOOKUP, 32'sd2, 32'h0000_0000);
        send_request(KIND_INSERT, 32'sh7FFF_FFFF, 32'h7FFF_FFFE);
        send_request(KIND_LOOKUP, 32'sh7FFF_FFFF, 32'h0000_0000);
        send_request(KIND_LOOKUP, 32'sh7FFF_FFFE, 32'h0000_0000);

        // Let the block drain completely before the random phase.
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.outstanding() != 0) @(negedge aclk);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            quiet = (n >= 500 && n < 700);
            insert_chance = (known_keys.size() < DEPTH_DEF) ? 55 : 15;
            kind = ($urandom_range(99) < insert_chance) ? KIND_INSERT : KIND_LOOKUP;
            send_request(kind, pick_key(kind), $urandom);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
